/* sv/wfms_pkg.sv */
// ----------------------------------------------------------------------------
// wfms_pkg
// shared types, constants and trig/window functions for the spectrum block
// ----------------------------------------------------------------------------
package wfms_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned BinW    = 8;
  localparam int unsigned MagW    = 32;
  localparam int unsigned PartW   = 32;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN_RD,
    ST_WIN_MUL,
    ST_WIN_WR,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WR,
    ST_MAG_RD,
    ST_MAG_SQ,
    ST_MAG_SQRT,
    ST_MAG_WR
  } state_e;

  typedef struct packed {
    logic                 kind;
    logic signed [23:0]   sample_value;
    logic [7:0]           bin_index;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_bin;
    logic [31:0] bin_magnitude;
    logic [31:0] peak_magnitude;
    logic        spectrum_valid;
  } rsp_t;

  localparam logic [63:0] Q30One = 64'd1073741824;
  localparam logic [63:0] PiQ30  = 64'd3373259426;

  // t is the angle as a q0.32 fraction of a turn
  function automatic logic signed [31:0] trig_fn(input logic [63:0] t,
                                                 input logic       want_sin);
    logic [63:0] r, x, x2, a, sn, cs, tmp;
    logic [1:0]  q;
    logic        swap;
    logic signed [63:0] c, s;
    q = t[31:30];
    r = t & 64'h3FFF_FFFF;
    swap = r > (64'd1 << 29);
    if (swap) r = (64'd1 << 30) - r;
    x  = (r * PiQ30) >> 31;
    x2 = (x * x) >> 30;
    a = Q30One - x2 / 72;
    a = Q30One - ((x2 * a) >> 30) / 42;
    a = Q30One - ((x2 * a) >> 30) / 20;
    a = Q30One - ((x2 * a) >> 30) / 6;
    sn = (x * a) >> 30;
    a = Q30One - x2 / 90;
    a = Q30One - ((x2 * a) >> 30) / 56;
    a = Q30One - ((x2 * a) >> 30) / 30;
    a = Q30One - ((x2 * a) >> 30) / 12;
    cs = Q30One - ((x2 * a) >> 30) / 2;
    if (swap) begin
      tmp = sn; sn = cs; cs = tmp;
    end
    unique case (q)
      2'd0: begin c = cs;  s = sn;  end
      2'd1: begin c = -sn; s = cs;  end
      2'd2: begin c = -cs; s = -sn; end
      default: begin c = sn; s = -cs; end
    endcase
    trig_fn = want_sin ? s[31:0] : c[31:0];
  endfunction

  function automatic logic signed [31:0] window_fn(input logic [63:0] t);
    logic signed [63:0] c, w;
    c = 64'(trig_fn(t, 1'b0));
    w = (signed'(Q30One) - c) / 2;
    window_fn = w[31:0];
  endfunction

  function automatic logic [63:0] round_q30(input logic signed [63:0] v);
    logic [63:0] mag, r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << 29)) >> 30;
    round_q30 = v[63] ? -r : r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

endpackage

/* sv/wfms_if.sv */
// ----------------------------------------------------------------------------
// wfms_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface wfms_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/windowed_fft_magnitude_spectrum.sv */
// ----------------------------------------------------------------------------
// windowed_fft_magnitude_spectrum
// hann window, radix-2 fft and magnitude spectrum of a sample block
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   kind, sample_value, bin_index
// rsp      out  read_bin, bin_magnitude, peak_magnitude, spectrum_valid
//
// a load request stores a sample; the last of a block starts the transform:
// a window pass (read, multiply, write for each sample), the butterflies
// (N/2*log2 N: read, multiply, sum, write) and the shared square root unit
// (N/2-1 bins). a read request goes through the registered magnitude memory.
// rsp is held in an output register; req is not taken while it is full
// or while the transform runs. reset clears control and the valid flag.
module windowed_fft_magnitude_spectrum #(
  parameter int unsigned TRANSFORM_LENGTH = 512
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  wfms_if.sink   req,
  wfms_if.source rsp
);
  import wfms_pkg::*;

  localparam int unsigned N  = TRANSFORM_LENGTH;
  localparam int unsigned LW = $clog2(N);
  localparam int unsigned HW = LW - 1;
  localparam int unsigned SW = SampleW + LW + 1;

  logic signed [31:0] cos_rom [N/2];
  logic signed [31:0] sin_rom [N/2];
  logic signed [31:0] win_rom [N];
  for (genvar g = 0; g < N; g++) begin : g_rom
    localparam logic [63:0] WinTurn = ((64'(g) % 64'(N - 1)) << 32) / 64'(N - 1);
    localparam logic signed [31:0] WinVal = window_fn(WinTurn);
    if (g < N/2) begin : g_tw
      localparam logic [63:0] TwTurn = (64'(g) << 32) / 64'(N);
      localparam logic signed [31:0] CosVal = trig_fn(TwTurn, 1'b0);
      localparam logic signed [31:0] SinVal = trig_fn(TwTurn, 1'b1);
      assign cos_rom[g] = CosVal;
      assign sin_rom[g] = SinVal;
    end
    assign win_rom[g] = WinVal;
  end

  logic signed [23:0] smp_mem [N];
  logic [63:0]        wrk_mem [N];
  logic [31:0]        mag_mem [N/2];

  state_e state_q, state_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [SW-1:0] mean_q, mean_d;
  logic [31:0] peak_q, peak_d;
  logic valid_flag_q, valid_flag_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] off_q, off_d;
  logic [LW-1:0] j_q, j_d;
  logic rsp_v_q, rsp_v_d;
  logic rd_pend_q, rd_pend_d;
  rsp_t rsp_q, rsp_d;
  logic [7:0] rd_bin_q;
  logic rd_in_q;
  logic sq_go_q;

  logic signed [23:0] smp_rd_q;
  logic signed [31:0] win_q;
  logic signed [56:0] win_pr_q;
  logic [63:0] a_rd_q, b_rd_q;
  logic [31:0] mag_rd_q;
  logic signed [63:0] pr0_q, pr1_q, pr2_q, pr3_q;
  logic signed [63:0] tr_q, ti_q;
  logic [63:0] sq_q;

  logic [LW-1:0] rev_idx, pa, pb, bf_half;
  logic          smp_we, wrk_we_a, wrk_we_b, mag_we;
  logic [LW-1:0] wrk_ra, wrk_rb, wrk_wa, wrk_wb;
  logic [63:0]   wrk_wda, wrk_wdb;
  logic [31:0]   mag_wd;
  logic          sq_start, sq_done;
  logic [31:0]   sq_root;
  logic [63:0]   mag_full;
  logic [31:0]   mag_val;
  logic signed [63:0] yq;
  logic signed [24:0] d_val;
  logic          take;

  always_comb begin
    for (int b = 0; b < LW; b++) rev_idx[LW-1-b] = idx_q[b];
  end

  logic [LW-1:0] stg_q, stg_d;
  logic [LW-1:0] tw_idx;
  assign bf_half = LW'(1) << stg_q;
  assign pa = off_q + j_q;
  assign pb = pa + bf_half;
  assign tw_idx = LW'(j_q << (LW - 1 - stg_q));

  assign take = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE) && !rsp_v_q && !rd_pend_q;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;

  assign d_val = 25'(smp_rd_q) - 25'(mean_q);
  assign yq = signed'(round_q30(64'(win_pr_q)));
  assign mag_full = ({32'd0, sq_root} << 1) >> LW;
  assign mag_val = (mag_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag_full[31:0];

  wfms_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .op_i(sq_q), .done_o(sq_done), .root_o(sq_root)
  );

  always_comb begin
    logic signed [SW-1:0] s_new;
    logic signed [63:0] ar, ai;
    state_d = state_q; cnt_d = cnt_q; sum_d = sum_q; mean_d = mean_q;
    peak_d = peak_q; valid_flag_d = valid_flag_q; idx_d = idx_q;
    off_d = off_q; j_d = j_q; stg_d = stg_q;
    rsp_v_d = rsp_v_q; rd_pend_d = 1'b0; rsp_d = rsp_q;
    smp_we = 1'b0; wrk_we_a = 1'b0; wrk_we_b = 1'b0; mag_we = 1'b0;
    wrk_ra = pa; wrk_rb = pb; wrk_wa = pa; wrk_wb = pb;
    wrk_wda = '0; wrk_wdb = '0; mag_wd = mag_val; sq_start = sq_go_q;
    s_new = sum_q + SW'(req.data.sample_value);
    ar = 64'(signed'(a_rd_q[63:32])); ai = 64'(signed'(a_rd_q[31:0]));
    if (rsp.valid && rsp.ready) rsp_v_d = 1'b0;
    if (rd_pend_q) begin
      rsp_v_d = 1'b1;
      rsp_d.read_bin = rd_bin_q;
      rsp_d.bin_magnitude = (valid_flag_q && rd_in_q) ? mag_rd_q : '0;
      rsp_d.peak_magnitude = peak_q;
      rsp_d.spectrum_valid = valid_flag_q;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (req.data.kind == KIND_READ) begin
            rd_pend_d = 1'b1;
          end else begin
            smp_we = 1'b1;
            if (cnt_q == LW'(N - 1)) begin
              mean_d = s_new >>> LW;
              cnt_d = '0; sum_d = '0; idx_d = '0;
              state_d = ST_WIN_RD;
            end else begin
              cnt_d = cnt_q + 1'b1; sum_d = s_new;
            end
          end
        end
      end
      ST_WIN_RD:  state_d = ST_WIN_MUL;
      ST_WIN_MUL: state_d = ST_WIN_WR;
      ST_WIN_WR: begin
        wrk_we_a = 1'b1; wrk_wa = rev_idx;
        wrk_wda = {sat32(yq), 32'd0};
        if (idx_q == LW'(N - 1)) begin
          off_d = '0; j_d = '0; stg_d = '0;
          state_d = ST_BF_RD;
        end else begin
          idx_d = idx_q + 1'b1; state_d = ST_WIN_RD;
        end
      end
      ST_BF_RD:  state_d = ST_BF_MUL;
      ST_BF_MUL: state_d = ST_BF_SUM;
      ST_BF_SUM: state_d = ST_BF_WR;
      ST_BF_WR: begin
        wrk_we_a = 1'b1; wrk_we_b = 1'b1;
        wrk_wda = {sat32(ar + tr_q), sat32(ai + ti_q)};
        wrk_wdb = {sat32(ar - tr_q), sat32(ai - ti_q)};
        state_d = ST_BF_RD;
        if (j_q == bf_half - 1'b1) begin
          j_d = '0;
          if (32'(off_q) + (32'(bf_half) << 1) >= 32'(N)) begin
            off_d = '0;
            if (stg_q == LW'(LW - 1)) begin
              idx_d = LW'(1); state_d = ST_MAG_RD;
            end else begin
              stg_d = stg_q + 1'b1;
            end
          end else begin
            off_d = off_q + (bf_half << 1);
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_MAG_RD: begin
        wrk_ra = idx_q; state_d = ST_MAG_SQ;
      end
      ST_MAG_SQ: state_d = ST_MAG_SQRT;
      ST_MAG_SQRT: begin
        if (sq_done) state_d = ST_MAG_WR;
      end
      ST_MAG_WR: begin
        mag_we = 1'b1;
        if (mag_val > peak_d) peak_d = mag_val;
        if (idx_q == LW'(N/2 - 1)) begin
          state_d = ST_IDLE; valid_flag_d = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1; state_d = ST_MAG_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_WIN_WR && idx_q == LW'(N - 1)) peak_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; sum_q <= '0; peak_q <= '0;
      valid_flag_q <= 1'b0; rsp_v_q <= 1'b0; rd_pend_q <= 1'b0;
      sq_go_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; sum_q <= sum_d; peak_q <= peak_d;
      valid_flag_q <= valid_flag_d; rsp_v_q <= rsp_v_d; rd_pend_q <= rd_pend_d;
      sq_go_q <= (state_q == ST_MAG_SQ);
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d; idx_q <= idx_d; off_q <= off_d;
    j_q <= j_d; stg_q <= stg_d; rsp_q <= rsp_d;
    if (take) begin
      rd_bin_q <= req.data.bin_index;
      rd_in_q  <= (req.data.bin_index != '0) && (32'(req.data.bin_index) < N/2);
      mag_rd_q <= mag_mem[HW'(req.data.bin_index)];
    end
    if (smp_we) smp_mem[cnt_q] <= req.data.sample_value;
    smp_rd_q <= smp_mem[idx_q];
    win_q <= win_rom[idx_q];
    win_pr_q <= d_val * win_q;
    if (wrk_we_a) wrk_mem[wrk_wa] <= wrk_wda;
    if (wrk_we_b) wrk_mem[wrk_wb] <= wrk_wdb;
    a_rd_q <= wrk_mem[wrk_ra];
    b_rd_q <= wrk_mem[wrk_rb];
    if (mag_we) mag_mem[HW'(idx_q)] <= mag_wd;
    pr0_q <= 64'(signed'(b_rd_q[63:32])) * 64'(cos_rom[HW'(tw_idx)]);
    pr1_q <= 64'(signed'(b_rd_q[31:0]))  * 64'(sin_rom[HW'(tw_idx)]);
    pr2_q <= 64'(signed'(b_rd_q[31:0]))  * 64'(cos_rom[HW'(tw_idx)]);
    pr3_q <= 64'(signed'(b_rd_q[63:32])) * 64'(sin_rom[HW'(tw_idx)]);
    tr_q <= signed'(round_q30(pr0_q + pr1_q));
    ti_q <= signed'(round_q30(pr2_q - pr3_q));
    sq_q <= 64'(signed'(a_rd_q[63:32])) * 64'(signed'(a_rd_q[63:32]))
          + 64'(signed'(a_rd_q[31:0])) * 64'(signed'(a_rd_q[31:0]));
  end

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !req.ready) else $error("ready while busy");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("response dropped");
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_flag_q |=> valid_flag_q) else $error("valid flag cleared");
endmodule

/* sv/wfms_sqrt.sv */
// ----------------------------------------------------------------------------
// wfms_sqrt
// bit-pair iterative integer square root of a 64-bit value
// ----------------------------------------------------------------------------
module wfms_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] op_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] n_q, n_d, res_q, res_d, bit_q, bit_d;
  logic        busy_q, busy_d;

  always_comb begin
    n_d = n_q; res_d = res_q; bit_d = bit_q; busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      n_d = op_i; res_d = '0; bit_d = 64'd1 << 62; busy_d = 1'b1;
    end else if (busy_q) begin
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (n_q >= res_q + bit_q) begin
          n_d = n_q - (res_q + bit_q);
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
    end
  end

  assign root_o = res_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; res_q <= res_d; bit_q <= bit_d;
  end
endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the windowed fft magnitude spectrum block: blocks
// of samples are loaded, spectra are predicted here and every read response
// is compared with the predicted bin, magnitude, peak and valid flag
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wfms_pkg::*;

  localparam int unsigned NLen   = 512;
  localparam int unsigned NHalf  = NLen / 2;
  localparam int unsigned NLog   = 9;
  localparam int unsigned Limit  = 3000000;
  localparam longint unsigned QOne = 64'd1073741824;
  localparam longint unsigned QPi  = 64'd3373259426;

  typedef struct {
    kind_e          kind;
    logic [23:0]    value;
    logic [7:0]     bin;
    bit             typed;
    logic [31:0]    mag;
    logic [31:0]    peak;
    logic           vld;
  } row_t;

  logic clk_i;
  logic rst_ni;
  wfms_if #(.T(req_t)) req_ch ();
  wfms_if #(.T(rsp_t)) rsp_ch ();

  windowed_fft_magnitude_spectrum #(.TRANSFORM_LENGTH(NLen)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch.sink),
    .rsp    (rsp_ch.source)
  );

  // spectrum predictor state
  longint            cos_tab [NHalf];
  longint            sin_tab [NHalf];
  longint            win_tab [NLen];
  logic signed [23:0] samples [NLen];
  longint            wre [NLen];
  longint            wim [NLen];
  logic [31:0]       mags [NHalf];
  int unsigned       n_loaded;
  longint            sum_acc;
  logic [31:0]       peak_q;
  bit                have_spectrum;

  rsp_t        pending_q [$];
  int unsigned errors;
  int unsigned cycles;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic turn_cs(input longint unsigned k, input longint unsigned m,
                         output longint c, output longint s);
    longint unsigned t, r, x, x2, a, sv, cv, tmp;
    bit sw;
    t = (((k % m) << 32) / m) & 64'hFFFF_FFFF;
    r = t & 64'h3FFF_FFFF;
    sw = r > (64'd1 << 29);
    if (sw) r = (64'd1 << 30) - r;
    x  = (r * QPi) >> 31;
    x2 = (x * x) >> 30;
    a = QOne - x2 / 72;
    a = QOne - ((x2 * a) >> 30) / 42;
    a = QOne - ((x2 * a) >> 30) / 20;
    a = QOne - ((x2 * a) >> 30) / 6;
    sv = (x * a) >> 30;
    a = QOne - x2 / 90;
    a = QOne - ((x2 * a) >> 30) / 56;
    a = QOne - ((x2 * a) >> 30) / 30;
    a = QOne - ((x2 * a) >> 30) / 12;
    cv = QOne - ((x2 * a) >> 30) / 2;
    if (sw) begin
      tmp = sv; sv = cv; cv = tmp;
    end
    case (t >> 30)
      0: begin c = longint'(cv);  s = longint'(sv);  end
      1: begin c = -longint'(sv); s = longint'(cv);  end
      2: begin c = -longint'(cv); s = -longint'(sv); end
      default: begin c = longint'(sv); s = -longint'(cv); end
    endcase
  endtask

  function automatic longint div_q30(input longint v);
    longint unsigned u;
    if (v < 0) begin
      u = longint'(-v);
      return -longint'((u + (64'd1 << 29)) >> 30);
    end
    u = v;
    return longint'((u + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic build_spectrum();
    longint mean, d, c, s, br, bi, tr, ti, ar, ai;
    longint unsigned sq, m;
    int unsigned rev, half, stride, p, q, w;
    logic [31:0] mg, pk;
    if (sum_acc >= 0) mean = longint'(longint'(sum_acc) >>> NLog);
    else mean = -longint'((longint'(-sum_acc) + NLen - 1) >>> NLog);
    for (int i = 0; i < NLen; i++) begin
      d = longint'(samples[i]) - mean;
      rev = 0;
      for (int b = 0; b < NLog; b++) rev |= ((i >> b) & 1) << (NLog - 1 - b);
      wre[rev] = clip32(div_q30(d * win_tab[i]));
      wim[rev] = 0;
    end
    for (int len = 2; len <= NLen; len = len << 1) begin
      half = len / 2;
      stride = NLen / len;
      for (int off = 0; off < NLen; off += len) begin
        for (int j = 0; j < half; j++) begin
          p = off + j;
          q = p + half;
          w = (j * stride) % NHalf;
          c = cos_tab[w];
          s = sin_tab[w];
          br = wre[q];
          bi = wim[q];
          tr = div_q30(br * c + bi * s);
          ti = div_q30(bi * c - br * s);
          ar = wre[p];
          ai = wim[p];
          wre[p] = clip32(ar + tr);
          wim[p] = clip32(ai + ti);
          wre[q] = clip32(ar - tr);
          wim[q] = clip32(ai - ti);
        end
      end
    end
    mags[0] = '0;
    pk = '0;
    for (int i = 1; i < NHalf; i++) begin
      sq = longint'(wre[i] * wre[i]) + longint'(wim[i] * wim[i]);
      m = (2 * root64(sq)) >> NLog;
      mg = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
      mags[i] = mg;
      if (mg > pk) pk = mg;
    end
    peak_q = pk;
    have_spectrum = 1'b1;
  endtask

  // advances the predictor by one accepted request
  task automatic predict_request(input req_t r, output rsp_t e);
    e = '0;
    if (r.kind == KIND_LOAD) begin
      samples[n_loaded] = r.sample_value;
      sum_acc += longint'(r.sample_value);
      n_loaded++;
      if (n_loaded >= NLen) begin
        build_spectrum();
        n_loaded = 0;
        sum_acc = 0;
      end
    end else begin
      e.read_bin = r.bin_index;
      e.bin_magnitude = (have_spectrum && r.bin_index < NHalf) ? mags[r.bin_index] : '0;
      e.peak_magnitude = peak_q;
      e.spectrum_valid = have_spectrum;
    end
  endtask

  task automatic send_request(input kind_e k, input logic [23:0] v, input logic [7:0] b,
                              input bit typed, input rsp_t typed_rsp);
    req_t r;
    rsp_t e;
    r.kind = k;
    r.sample_value = v;
    r.bin_index = b;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_request(r, e);
    if (k == KIND_READ) pending_q.insert(pending_q.size(), typed ? typed_rsp : e);
  endtask

  task automatic read_bin(input logic [7:0] b);
    send_request(KIND_READ, '0, b, 1'b0, '0);
  endtask

  // a run of samples; shape picks the waveform, reads are mixed in
  task automatic load_block(input int count, input int shape, input int read_odds);
    logic [23:0] v;
    int unsigned per;
    per = $urandom_range(2, 64);
    for (int i = 0; i < count; i++) begin
      case (shape)
        0: v = 24'($urandom);
        1: v = (i % 2) ? 24'h800000 : 24'h7FFFFF;
        2: v = 24'(-(200000 + int'($urandom_range(0, 4000))));
        default: v = ((i % per) < per / 2) ? 24'(1 << $urandom_range(4, 20))
                                            : 24'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, read_odds) == 0) read_bin(8'($urandom));
      send_request(KIND_LOAD, v, 8'($urandom), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall = 0;
    end else if (quiet) begin
      rsp_ch.ready <= 1'b1;
    end else if (stall != 0) begin
      stall--;
      rsp_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall = $urandom_range(1, 16);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected response %p", $realtime, rsp_ch.data);
        errors++;
      end else begin
        e = pending_q[0];
        pending_q.delete(0);
        if (rsp_ch.data.read_bin !== e.read_bin) begin
          $display("%0t: read_bin expected %0d actual %0d", $realtime, e.read_bin,
                   rsp_ch.data.read_bin);
          errors++;
        end
        if (rsp_ch.data.bin_magnitude !== e.bin_magnitude) begin
          $display("%0t: bin_magnitude bin %0d expected %h actual %h", $realtime,
                   e.read_bin, e.bin_magnitude, rsp_ch.data.bin_magnitude);
          errors++;
        end
        if (rsp_ch.data.peak_magnitude !== e.peak_magnitude) begin
          $display("%0t: peak_magnitude expected %h actual %h", $realtime,
                   e.peak_magnitude, rsp_ch.data.peak_magnitude);
          errors++;
        end
        if (rsp_ch.data.spectrum_valid !== e.spectrum_valid) begin
          $display("%0t: spectrum_valid expected %b actual %b", $realtime,
                   e.spectrum_valid, rsp_ch.data.spectrum_valid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    rsp_t tr;
    int unsigned wait_n;
    longint c, s;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    n_loaded = 0;
    sum_acc = 0;
    peak_q = '0;
    have_spectrum = 1'b0;
    for (int i = 0; i < NHalf; i++) begin
      turn_cs(i, NLen, c, s);
      cos_tab[i] = c;
      sin_tab[i] = s;
      mags[i] = '0;
    end
    for (int i = 0; i < NLen; i++) begin
      turn_cs(i, NLen - 1, c, s);
      win_tab[i] = (longint'(QOne) - c) / 2;
    end
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reads before any spectrum, extreme samples, a read while loading
    rows = '{
      '{KIND_READ, 24'h000000, 8'd0,   1'b1, 32'd0, 32'd0, 1'b0},
      '{KIND_READ, 24'hFFFFFF, 8'd255, 1'b1, 32'd0, 32'd0, 1'b0},
      '{KIND_READ, 24'h000000, 8'd128, 1'b1, 32'd0, 32'd0, 1'b0},
      '{KIND_READ, 24'h000000, 8'd1,   1'b1, 32'd0, 32'd0, 1'b0},
      '{KIND_LOAD, 24'h7FFFFF, 8'd255, 1'b0, 32'd0, 32'd0, 1'b0},
      '{KIND_LOAD, 24'h800000, 8'd0,   1'b0, 32'd0, 32'd0, 1'b0},
      '{KIND_LOAD, 24'h000000, 8'd0,   1'b0, 32'd0, 32'd0, 1'b0},
      '{KIND_LOAD, 24'hFFFFFF, 8'd170, 1'b0, 32'd0, 32'd0, 1'b0},
      '{KIND_READ, 24'h7FFFFF, 8'd2,   1'b1, 32'd0, 32'd0, 1'b0},
      '{KIND_LOAD, 24'h555555, 8'd85,  1'b0, 32'd0, 32'd0, 1'b0},
      '{KIND_LOAD, 24'hAAAAAA, 8'd0,   1'b0, 32'd0, 32'd0, 1'b0}
    };
    foreach (rows[i]) begin
      tr.read_bin = rows[i].bin;
      tr.bin_magnitude = rows[i].mag;
      tr.peak_magnitude = rows[i].peak;
      tr.spectrum_valid = rows[i].vld;
      send_request(rows[i].kind, rows[i].value, rows[i].bin, rows[i].typed, tr);
    end
    // finish the first block with alternating extremes to drive saturation
    for (int i = n_loaded; i < NLen; i++)
      send_request(KIND_LOAD, (i % 2) ? 24'h800000 : 24'h7FFFFF, '0, 1'b0, '0);
    read_bin(8'd0);
    read_bin(8'd255);
    read_bin(8'd1);

    // hold off until every read response is back
    req_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);

    load_block(40, 0, 2);
    for (int i = 0; i < 10; i++) read_bin(8'($urandom));
    quiet = 1'b1;
    for (int i = 0; i < 40; i++) read_bin(8'($urandom));
    req_ch.valid <= 1'b0;

    wait_n = 0;
    while (pending_q.size() != 0 && wait_n < 100000) begin
      @(posedge clk_i);
      wait_n++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* windowed_fft_magnitude_spectrum.f */
sv/wfms_pkg.sv
sv/wfms_if.sv
sv/wfms_sqrt.sv
sv/windowed_fft_magnitude_spectrum.sv
bench/tb_top.sv
